// ----- rtl/pif_pkg.sv -----
// Shared types and constants for the point-in-figures hit test unit.
`timescale 1ns / 1ps

package pif_pkg;

    localparam int COORD_W         = 24;
    localparam int RADIUS_W        = 23;
    localparam int PNUM_W          = 16;
    localparam int FNUM_W          = 5;
    localparam int ENTRY_W         = 1 + 4 * COORD_W;
    localparam int DEF_MAX_FIGURES = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_RECT   = 2'd1,
        CMD_CIRCLE = 2'd2,
        CMD_QUERY  = 2'd3
    } pif_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END
    } pif_state_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;
        logic wr_circle;
        logic load_query;
        logic tok_vld;
        logic tok_fin;
    } pif_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic advance;
        logic busy;
    } pif_stat_t;

endpackage

// ----- rtl/pif_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module pif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pif_ctrl.sv -----
// Command sequencer: figure and point counters, query scan of the figure table.
`timescale 1ns / 1ps

module pif_ctrl
    import pif_pkg::*;
#(
    parameter int MAX_FIGURES = DEF_MAX_FIGURES,
    localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1,
    localparam int CNT_W = $clog2(MAX_FIGURES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pif_cmd_t          command,
    input  pif_stat_t         stat,
    output pif_ctl_t          ctl,
    output logic [IDX_W-1:0]  fig_addr,
    output logic [PNUM_W-1:0] point_number
);

    pif_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PNUM_W-1:0] pcount_reg, pcount_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              accept;
    logic              full;
    logic              scan_last;

    assign full      = (count_reg == CNT_W'(MAX_FIGURES));
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pcount_reg <= '0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pcount_reg <= pcount_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pcount_next  = pcount_reg;
        idx_next     = idx_reg;
        ctl          = '0;
        fig_addr     = idx_reg;
        point_number = pcount_reg;
        s_tready     = 1'b0;
        accept       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = !stat.busy;
                accept   = s_tvalid && s_tready;
                fig_addr = count_reg[IDX_W-1:0];
                if (accept) begin
                    case (command)
                        CMD_CLEAR: begin
                            count_next  = '0;
                            pcount_next = '0;
                        end
                        CMD_RECT, CMD_CIRCLE: begin
                            if (!full) begin
                                ctl.wr_en     = 1'b1;
                                ctl.wr_circle = (command == CMD_CIRCLE);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (pcount_reg != {PNUM_W{1'b1}}) begin
                                pcount_next = pcount_reg + PNUM_W'(1);
                            end
                            point_number   = pcount_next;
                            ctl.load_query = 1'b1;
                            idx_next       = '0;
                            state_next     = (count_reg == '0) ? ST_END : ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                ctl.tok_vld = 1'b1;
                if (stat.advance) begin
                    if (scan_last) begin
                        state_next = ST_END;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_END: begin
                ctl.tok_vld = 1'b1;
                ctl.tok_fin = 1'b1;
                if (stat.advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FIGURES))
        else $error("figure count above table size");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CNT_W'(idx_reg) < count_reg)
        else $error("scan index beyond stored figures");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && command == CMD_QUERY) |=> state_reg != ST_IDLE)
        else $error("accepted query did not start a scan");
`endif

endmodule

// ----- rtl/pif_dp.sv -----
// Figure table, four-stage containment test pipeline and result collector.
`timescale 1ns / 1ps

module pif_dp
    import pif_pkg::*;
#(
    parameter int MAX_FIGURES = DEF_MAX_FIGURES,
    localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1,
    localparam int SQ_W  = 2 * RADIUS_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pif_ctl_t            ctl,
    output pif_stat_t           stat,
    input  logic [IDX_W-1:0]    fig_addr,
    input  logic [PNUM_W-1:0]   point_number,
    input  logic [COORD_W-1:0]  rect_left,
    input  logic [COORD_W-1:0]  rect_top,
    input  logic [COORD_W-1:0]  rect_right,
    input  logic [COORD_W-1:0]  rect_bottom,
    input  logic [COORD_W-1:0]  circle_x,
    input  logic [COORD_W-1:0]  circle_y,
    input  logic [RADIUS_W-1:0] circle_radius,
    input  logic [COORD_W-1:0]  point_x,
    input  logic [COORD_W-1:0]  point_y,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PNUM_W-1:0]   m_pnum,
    output logic [FNUM_W-1:0]   m_fnum,
    output logic                m_contained,
    output logic                m_tlast
);

    logic               adv;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    // query operands
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [PNUM_W-1:0]  pnum_reg;

    // stage 1: table read
    logic               t1_vld_reg, t1_fin_reg;
    logic [IDX_W-1:0]   t1_idx_reg;

    // stage 2: compares and distances
    logic                t2_vld_reg, t2_fin_reg;
    logic [IDX_W-1:0]    t2_idx_reg;
    logic                t2_rect_reg, t2_circ_reg, t2_near_reg;
    logic [RADIUS_W-1:0] t2_dx_reg, t2_dy_reg, t2_r_reg;
    logic                t2_rect_next, t2_near_next;
    logic [COORD_W:0]    dx_diff, dy_diff, dx_mag, dy_mag;

    // stage 3: squares
    logic                t3_vld_reg, t3_fin_reg;
    logic [IDX_W-1:0]    t3_idx_reg;
    logic                t3_rect_reg, t3_circ_reg, t3_near_reg;
    logic [SQ_W-1:0]     t3_sqx_reg, t3_sqy_reg, t3_sqr_reg;

    // stage 4: hit decision
    logic                t4_vld_reg, t4_fin_reg, t4_hit_reg;
    logic [IDX_W-1:0]    t4_idx_reg;
    logic                t4_hit_next;

    // collector: most recent hit waits until it is known whether it is the last
    logic                held_vld_reg, held_vld_next;
    logic [FNUM_W-1:0]   held_num_reg, held_num_next;
    logic [FNUM_W-1:0]   t4_num;

    logic                out_vld_reg, out_vld_next;
    logic [PNUM_W-1:0]   out_pnum_reg, out_pnum_next;
    logic [FNUM_W-1:0]   out_fnum_reg, out_fnum_next;
    logic                out_cont_reg, out_cont_next;
    logic                out_last_reg, out_last_next;

    logic [COORD_W-1:0]  ea, eb, ec, ed;
    logic                e_circ;

    assign adv          = !out_vld_reg || m_tready;
    assign stat.advance = adv;
    assign stat.busy    = t1_vld_reg || t2_vld_reg || t3_vld_reg || t4_vld_reg;

    // entry layout, low to high: word a, b, c, d, circle flag
    assign wr_entry = ctl.wr_circle
        ? {1'b1, {COORD_W{1'b0}}, COORD_W'(circle_radius), circle_y, circle_x}
        : {1'b0, rect_bottom, rect_right, rect_top, rect_left};

    pif_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FIGURES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (fig_addr),
        .wr_data (wr_entry),
        .rd_en   (adv),
        .rd_addr (fig_addr),
        .rd_data (rd_entry)
    );

    assign ea     = rd_entry[COORD_W-1:0];
    assign eb     = rd_entry[2*COORD_W-1:COORD_W];
    assign ec     = rd_entry[3*COORD_W-1:2*COORD_W];
    assign ed     = rd_entry[4*COORD_W-1:3*COORD_W];
    assign e_circ = rd_entry[ENTRY_W-1];

    always_comb begin
        t2_rect_next = ($signed(ea) < $signed(px_reg)) && ($signed(ec) > $signed(px_reg)) &&
                       ($signed(eb) > $signed(py_reg)) && ($signed(ed) < $signed(py_reg));
        dx_diff      = {ea[COORD_W-1], ea} - {px_reg[COORD_W-1], px_reg};
        dy_diff      = {eb[COORD_W-1], eb} - {py_reg[COORD_W-1], py_reg};
        dx_mag       = dx_diff[COORD_W] ? (~dx_diff + (COORD_W+1)'(1)) : dx_diff;
        dy_mag       = dy_diff[COORD_W] ? (~dy_diff + (COORD_W+1)'(1)) : dy_diff;
        // both offsets below the radius keeps the squares in 2*RADIUS_W bits
        t2_near_next = (dx_mag < (COORD_W+1)'(ec[RADIUS_W-1:0])) &&
                       (dy_mag < (COORD_W+1)'(ec[RADIUS_W-1:0]));
    end

    always_comb begin
        if (t3_circ_reg) begin
            t4_hit_next = t3_near_reg &&
                ((SQ_W+1)'(t3_sqx_reg) + (SQ_W+1)'(t3_sqy_reg) < (SQ_W+1)'(t3_sqr_reg));
        end else begin
            t4_hit_next = t3_rect_reg;
        end
    end

    assign t4_num = FNUM_W'((IDX_W+1)'(t4_idx_reg) + (IDX_W+1)'(1));

    always_comb begin
        held_vld_next = held_vld_reg;
        held_num_next = held_num_reg;
        out_vld_next  = out_vld_reg;
        out_pnum_next = out_pnum_reg;
        out_fnum_next = out_fnum_reg;
        out_cont_next = out_cont_reg;
        out_last_next = out_last_reg;
        if (adv) begin
            out_vld_next = 1'b0;
            if (t4_vld_reg) begin
                if (t4_fin_reg) begin
                    out_vld_next  = 1'b1;
                    out_pnum_next = pnum_reg;
                    out_fnum_next = held_vld_reg ? held_num_reg : '0;
                    out_cont_next = held_vld_reg;
                    out_last_next = 1'b1;
                    held_vld_next = 1'b0;
                end else if (t4_hit_reg) begin
                    out_vld_next  = held_vld_reg;
                    out_pnum_next = pnum_reg;
                    out_fnum_next = held_num_reg;
                    out_cont_next = 1'b1;
                    out_last_next = 1'b0;
                    held_vld_next = 1'b1;
                    held_num_next = t4_num;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            t3_vld_reg   <= 1'b0;
            t4_vld_reg   <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (adv) begin
                t1_vld_reg <= ctl.tok_vld;
                t2_vld_reg <= t1_vld_reg;
                t3_vld_reg <= t2_vld_reg;
                t4_vld_reg <= t3_vld_reg;
            end
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_query) begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            pnum_reg <= point_number;
        end
        if (adv) begin
            t1_fin_reg  <= ctl.tok_fin;
            t1_idx_reg  <= fig_addr;

            t2_fin_reg  <= t1_fin_reg;
            t2_idx_reg  <= t1_idx_reg;
            t2_rect_reg <= t2_rect_next;
            t2_circ_reg <= e_circ;
            t2_near_reg <= t2_near_next;
            t2_dx_reg   <= dx_mag[RADIUS_W-1:0];
            t2_dy_reg   <= dy_mag[RADIUS_W-1:0];
            t2_r_reg    <= ec[RADIUS_W-1:0];

            t3_fin_reg  <= t2_fin_reg;
            t3_idx_reg  <= t2_idx_reg;
            t3_rect_reg <= t2_rect_reg;
            t3_circ_reg <= t2_circ_reg;
            t3_near_reg <= t2_near_reg;
            t3_sqx_reg  <= SQ_W'(t2_dx_reg) * SQ_W'(t2_dx_reg);
            t3_sqy_reg  <= SQ_W'(t2_dy_reg) * SQ_W'(t2_dy_reg);
            t3_sqr_reg  <= SQ_W'(t2_r_reg) * SQ_W'(t2_r_reg);

            t4_fin_reg  <= t3_fin_reg;
            t4_idx_reg  <= t3_idx_reg;
            t4_hit_reg  <= t4_hit_next;
        end
        held_num_reg <= held_num_next;
        out_pnum_reg <= out_pnum_next;
        out_fnum_reg <= out_fnum_next;
        out_cont_reg <= out_cont_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid    = out_vld_reg;
    assign m_pnum      = out_pnum_reg;
    assign m_fnum      = out_fnum_reg;
    assign m_contained = out_cont_reg;
    assign m_tlast     = out_last_reg;

`ifndef SYNTHESIS
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && t4_vld_reg && t4_fin_reg) |=> (out_vld_reg && out_last_reg && !held_vld_reg))
        else $error("end of scan did not produce the final beat");

    a_miss_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_cont_reg) |-> (out_last_reg && out_fnum_reg == '0))
        else $error("not-contained beat is not a lone final beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready) |=> (out_vld_reg && $stable(out_pnum_reg) &&
            $stable(out_fnum_reg) && $stable(out_cont_reg) && $stable(out_last_reg)))
        else $error("result beat changed while waiting");
`endif

endmodule

// ----- rtl/point_in_figures_hit_test_unit.sv -----
// Top level of the point-in-figures hit test unit.
// A query tests the N stored figures, one per cycle while the output is not
//   stalled, in a four-stage test pipeline fed from the figure table RAM.
// Throughput: one input beat per cycle for clear and add while no query is in
//   flight; a new query is accepted only after the previous one has drained.
// Reset: synchronous active-low aresetn clears both counters, the sequencer and
//   all valid flags; the table is not cleared; only entries below count are tested.
`timescale 1ns / 1ps

module point_in_figures_hit_test_unit
    import pif_pkg::*;
#(
    parameter int MAX_FIGURES = DEF_MAX_FIGURES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rect_left, rect_top, rect_right, rect_bottom, circle_x, circle_y,
    // circle_radius, point_x, point_y, one pad bit
    input  logic [215:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_number, figure_number, three pad bits
    output logic [23:0]  m_tdata,
    // contained
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;

    pif_ctl_t          ctl;
    pif_stat_t         stat;
    logic [IDX_W-1:0]  fig_addr;
    logic [PNUM_W-1:0] point_number;
    logic [PNUM_W-1:0] m_pnum;
    logic [FNUM_W-1:0] m_fnum;
    logic              m_contained;

    // sequencer: counters, table write, scan of stored figures
    pif_ctrl #(
        .MAX_FIGURES (MAX_FIGURES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .command      (pif_cmd_t'(s_tuser)),
        .stat         (stat),
        .ctl          (ctl),
        .fig_addr     (fig_addr),
        .point_number (point_number)
    );

    // table, containment pipeline, result collector and output register
    pif_dp #(
        .MAX_FIGURES (MAX_FIGURES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .fig_addr      (fig_addr),
        .point_number  (point_number),
        .rect_left     (s_tdata[23:0]),
        .rect_top      (s_tdata[47:24]),
        .rect_right    (s_tdata[71:48]),
        .rect_bottom   (s_tdata[95:72]),
        .circle_x      (s_tdata[119:96]),
        .circle_y      (s_tdata[143:120]),
        .circle_radius (s_tdata[166:144]),
        .point_x       (s_tdata[190:167]),
        .point_y       (s_tdata[214:191]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_pnum        (m_pnum),
        .m_fnum        (m_fnum),
        .m_contained   (m_contained),
        .m_tlast       (m_tlast)
    );

    assign m_tdata = {3'b000, m_fnum, m_pnum};
    assign m_tuser = m_contained;

endmodule
